[hw/rtl/tst_pkg.sv]
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and constants of the tab stop table: request and response
// payloads, opcodes, status codes and the table entry layout.
// ----------------------------------------------------------------------------
package tst_pkg;

	localparam int MAX_STOPS_DEF = 32;
	localparam int DEFAULT_STEP  = 36;
	localparam int DEFAULT_LIMIT = 720;
	localparam int DEFAULT_COUNT = (DEFAULT_LIMIT - 1) / DEFAULT_STEP;
	localparam int POS_W         = 16;
	localparam int KIND_W        = 3;
	localparam int ENTRY_W       = POS_W + KIND_W;

	typedef enum logic [2:0] {
		OP_ADD_LEFT     = 3'd0,
		OP_ADD_RIGHT    = 3'd1,
		OP_ADD_CENTER   = 3'd2,
		OP_ADD_CBETWEEN = 3'd3,
		OP_ADD_CHAR     = 3'd4,
		OP_DIVIDE       = 3'd5,
		OP_DELETE       = 3'd6,
		OP_CLEAR        = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		STS_INSERTED  = 3'd0,
		STS_REPLACED  = 3'd1,
		STS_UNCHANGED = 3'd2,
		STS_DELETED   = 3'd3,
		STS_NOTFOUND  = 3'd4,
		STS_CLEARED   = 3'd5,
		STS_FULL      = 3'd6
	} status_t;

	typedef struct packed {
		opcode_t            opcode;
		logic signed [15:0] position;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [5:0] stop_count;
		logic [4:0] slot;
	} rsp_t;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic [KIND_W-1:0] kind;
	} entry_t;

endpackage

[hw/rtl/tst_ram.sv]
// ----------------------------------------------------------------------------
// tst_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/tst_ctrl.sv]
// ----------------------------------------------------------------------------
// tst_ctrl
// Sequencer of the tab stop table: loads the default stops, scans the table
// with one shared signed compare, and shifts entries one per cycle through
// the table RAM for inserts and deletes.
// ----------------------------------------------------------------------------
module tst_ctrl #(
	parameter int MAX_STOPS = tst_pkg::MAX_STOPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  tst_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output tst_pkg::rsp_t res
);

	import tst_pkg::*;

	localparam int IDX_W    = $clog2(MAX_STOPS);
	localparam int CNT_W    = $clog2(MAX_STOPS + 1);
	localparam int INIT_CNT = (DEFAULT_COUNT < MAX_STOPS) ? DEFAULT_COUNT : MAX_STOPS;

	typedef enum logic [5:0] {
		S_INIT  = 6'b000001,
		S_IDLE  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_SHIFT = 6'b001000,
		S_PUT   = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_q;
	logic [IDX_W-1:0] a_q;
	logic             dir_down_q;
	logic [POS_W-1:0] init_pos_q;
	opcode_t          op_q;
	logic [POS_W-1:0] pos_q;
	status_t          status_q;
	logic [IDX_W-1:0] slot_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_ent;

	logic             issue;
	logic             is_add;
	logic             pos_eq;
	logic             pos_gt;
	logic             dec;
	logic             dec_hit;
	logic [IDX_W-1:0] dec_idx;
	logic [CNT_W+5:0] cnt_ext;
	logic [IDX_W+4:0] slot_ext;

	tst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_STOPS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (a_q),
		.rdata (ram_rdata)
	);

	assign rd_ent = entry_t'(ram_rdata);
	assign issue  = (n_q != '0) && ((state_q == S_SCAN) || (state_q == S_SHIFT));
	assign is_add = (op_q == OP_ADD_LEFT) || (op_q == OP_ADD_RIGHT) ||
		(op_q == OP_ADD_CENTER) || (op_q == OP_ADD_CBETWEEN) || (op_q == OP_ADD_CHAR);

	// shared compare against the request position
	assign pos_eq = (rd_ent.position == pos_q);
	assign pos_gt = ($signed(rd_ent.position) > $signed(pos_q));

	always_comb begin
		dec     = 1'b0;
		dec_hit = 1'b0;
		dec_idx = count_q[IDX_W-1:0];
		if (state_q == S_SCAN) begin
			if (rd_vld_s1 && (pos_eq || pos_gt)) begin
				dec     = 1'b1;
				dec_hit = pos_eq;
				dec_idx = rd_idx_s1;
			end else if (!rd_vld_s1 && (n_q == '0)) begin
				dec = 1'b1;
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = a_q;
		ram_wdata = ram_rdata;
		case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = a_q;
				ram_wdata = {init_pos_q, KIND_W'(0)};
			end
			S_SCAN: begin
				if (dec && dec_hit && is_add && (rd_ent.kind != KIND_W'(op_q))) begin
					ram_we    = 1'b1;
					ram_waddr = dec_idx;
					ram_wdata = {rd_ent.position, KIND_W'(op_q)};
				end
			end
			S_SHIFT: begin
				ram_we    = rd_vld_s1;
				ram_waddr = dir_down_q ? (rd_idx_s1 + IDX_W'(1)) : (rd_idx_s1 - IDX_W'(1));
				ram_wdata = ram_rdata;
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = slot_q;
				ram_wdata = {pos_q, KIND_W'(op_q)};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			count_q    <= CNT_W'(INIT_CNT);
			n_q        <= CNT_W'(INIT_CNT);
			a_q        <= '0;
			dir_down_q <= 1'b0;
			init_pos_q <= POS_W'(DEFAULT_STEP);
			rd_vld_s1  <= 1'b0;
			status_q   <= STS_CLEARED;
			slot_q     <= '0;
		end else begin
			rd_vld_s1 <= issue;
			rd_idx_s1 <= a_q;
			if (issue) begin
				n_q <= n_q - CNT_W'(1);
				a_q <= dir_down_q ? (a_q - IDX_W'(1)) : (a_q + IDX_W'(1));
			end
			case (state_q)
				S_INIT: begin
					a_q        <= a_q + IDX_W'(1);
					n_q        <= n_q - CNT_W'(1);
					init_pos_q <= init_pos_q + POS_W'(DEFAULT_STEP);
					if (n_q == CNT_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						op_q  <= req.opcode;
						pos_q <= req.position;
						if ((req.opcode == OP_DIVIDE) || (req.opcode == OP_CLEAR)) begin
							count_q  <= '0;
							status_q <= STS_CLEARED;
							slot_q   <= '0;
							state_q  <= S_RESP;
						end else begin
							n_q        <= count_q;
							a_q        <= '0;
							dir_down_q <= 1'b0;
							state_q    <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (dec) begin
						rd_vld_s1 <= 1'b0;
						n_q       <= '0;
						state_q   <= S_RESP;
						slot_q    <= '0;
						if (is_add) begin
							if (dec_hit) begin
								slot_q   <= dec_idx;
								status_q <= (rd_ent.kind == KIND_W'(op_q)) ?
									STS_UNCHANGED : STS_REPLACED;
							end else if (count_q == CNT_W'(MAX_STOPS)) begin
								status_q <= STS_FULL;
							end else begin
								slot_q     <= dec_idx;
								status_q   <= STS_INSERTED;
								count_q    <= count_q + CNT_W'(1);
								n_q        <= count_q - CNT_W'(dec_idx);
								a_q        <= IDX_W'(count_q - CNT_W'(1));
								dir_down_q <= 1'b1;
								state_q    <= S_SHIFT;
							end
						end else begin
							if (dec_hit) begin
								slot_q     <= dec_idx;
								status_q   <= STS_DELETED;
								count_q    <= count_q - CNT_W'(1);
								n_q        <= count_q - CNT_W'(1) - CNT_W'(dec_idx);
								a_q        <= dec_idx + IDX_W'(1);
								dir_down_q <= 1'b0;
								state_q    <= S_SHIFT;
							end else begin
								status_q <= STS_NOTFOUND;
							end
						end
					end
				end
				S_SHIFT: begin
					if ((n_q == '0) && !rd_vld_s1) begin
						state_q <= (status_q == STS_INSERTED) ? S_PUT : S_RESP;
					end
				end
				S_PUT: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cnt_ext  = (CNT_W + 6)'(count_q);
	assign slot_ext = (IDX_W + 5)'(slot_q);

	assign req_ready      = (state_q == S_IDLE);
	assign res_valid      = (state_q == S_RESP);
	assign res.status     = status_q;
	assign res.stop_count = cnt_ext[5:0];
	assign res.slot       = slot_ext[4:0];

endmodule

[hw/rtl/tab_stop_table.sv]
// ----------------------------------------------------------------------------
// tab_stop_table
// Sorted table of tab stops with add, replace, delete and clear requests.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_ready  tst_pkg::req_t (opcode, position)
//   rsp       out        rsp_valid / rsp_ready  tst_pkg::rsp_t (status, stop_count, slot)
//
// A request scans the table RAM one entry per cycle through a single signed
// compare, then moves entries one per cycle for an insert or delete.
// A clear or divide request empties the table without a scan.
// After reset a pass writes the default stops; req_ready stays low until it ends.
// A finished response waits in the output register; the next request is
// taken meanwhile and completes once the register frees up.
// ----------------------------------------------------------------------------
module tab_stop_table #(
	parameter int MAX_STOPS = tst_pkg::MAX_STOPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  tst_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output tst_pkg::rsp_t rsp
);

	import tst_pkg::*;

	logic rsp_valid_q;
	rsp_t rsp_q;
	logic res_valid;
	logic res_ready;
	rsp_t res;

	tst_ctrl #(
		.MAX_STOPS (MAX_STOPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (res_ready) begin
				rsp_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
